// ----- hw/rtl/sha1md_pkg.sv -----
// Shared types, constants and helper functions of the SHA-1 digest block.
package sha1md_pkg;

  localparam int unsigned DIGEST_WORDS = 5;
  localparam int unsigned BLOCK_WORDS = 16;

  localparam logic [31:0] INIT_WORDS [DIGEST_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K_ROUND_0 = 32'h5A827999;
  localparam logic [31:0] K_ROUND_1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_ROUND_2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_ROUND_3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [5:0] LAST_BYTE = 6'd63;

  localparam logic [6:0] ROUND_20 = 7'd20;
  localparam logic [6:0] ROUND_40 = 7'd40;
  localparam logic [6:0] ROUND_60 = 7'd60;
  localparam logic [6:0] LAST_ROUND = 7'd79;

  localparam logic [2:0] LAST_INDEX = 3'(DIGEST_WORDS - 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } work_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_PAD2,
    ST_ROUND,
    ST_FOLD,
    ST_DONE
  } state_t;

  function automatic logic [31:0] rol1(input logic [31:0] x);
    return {x[30:0], x[31]};
  endfunction

  function automatic logic [31:0] rol5(input logic [31:0] x);
    return {x[26:0], x[31:27]};
  endfunction

  function automatic logic [31:0] rol30(input logic [31:0] x);
    return {x[1:0], x[31:2]};
  endfunction

endpackage

// ----- hw/rtl/sha1md_round.sv -----
// One SHA-1 compression round, shared by all eighty rounds of a block.
module sha1md_round
  import sha1md_pkg::*;
(
  input  work_t       cur,
  input  logic [31:0] w,
  input  logic [6:0]  rnd,
  output work_t       nxt
);

  logic [31:0] f;
  logic [31:0] k;

  always_comb begin
    priority if (rnd < ROUND_20) begin
      f = (cur.b & cur.c) | (~cur.b & cur.d);
      k = K_ROUND_0;
    end else if (rnd < ROUND_40) begin
      f = cur.b ^ cur.c ^ cur.d;
      k = K_ROUND_1;
    end else if (rnd < ROUND_60) begin
      f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
      k = K_ROUND_2;
    end else begin
      f = cur.b ^ cur.c ^ cur.d;
      k = K_ROUND_3;
    end
  end

  always_comb begin
    nxt.a = rol5(cur.a) + f + cur.e + k + w;
    nxt.b = cur.a;
    nxt.c = rol30(cur.b);
    nxt.d = cur.c;
    nxt.e = cur.d;
  end

endmodule

// ----- hw/rtl/sha1_message_digest.sv -----
// Top level of the SHA-1 digest block: byte buffer, sequencer and digest output.
//
//   Channel | Direction | Ports                        | Moves per transfer
//   in      | input     | in_valid, in_stall, in_item  | one byte and/or end mark
//   out     | output    | out_valid, out_stall, out_item | one 32-bit digest word
//
// A byte that does not fill a block is taken without a stall. The byte that fills
// a block stalls the input for load, eighty rounds in the shared round unit and
// fold; an end mark also pads, with a second block when 56 or more bytes pend.
// Digest words leave an output register one per cycle while out_stall is low,
// as the next message is taken; a new digest waits until the previous one has left.
// Reset is synchronous and sets the initial chaining words.
module sha1_message_digest
  import sha1md_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  state_t state_r;
  state_t state_nxt;

  logic [31:0] chain_r [DIGEST_WORDS];
  logic [31:0] wbuf_r [BLOCK_WORDS];
  logic [31:0] pad_words [BLOCK_WORDS];
  logic [31:0] dig_r [DIGEST_WORDS];
  logic [5:0]  fill_r;
  logic [63:0] bits_r;
  logic [6:0]  rnd_r;
  work_t       work_r;
  work_t       work_nxt;
  logic        close_pend_r;
  logic        tail_r;
  logic        final_r;
  logic        out_busy_r;
  logic [2:0]  out_idx_r;

  logic       in_acc;
  logic       out_acc;
  logic       block_full;
  logic       enter_round;
  logic       pad_en;
  logic       restart;
  logic [5:0] pad_fill;
  logic       pad_mark;
  logic       pad_len;

  assign in_acc = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign block_full = in_item.byte_present && (fill_r == LAST_BYTE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (block_full) begin
            state_nxt = ST_ROUND;
          end else if (in_item.end_of_message) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: state_nxt = ST_ROUND;
      ST_PAD2: state_nxt = ST_ROUND;
      ST_ROUND: begin
        if (rnd_r == LAST_ROUND) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        priority if (close_pend_r) begin
          state_nxt = ST_PAD;
        end else if (tail_r) begin
          state_nxt = ST_PAD2;
        end else if (final_r) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (!out_busy_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != ST_IDLE);
    pad_en = (state_r == ST_PAD) || (state_r == ST_PAD2);
    restart = (state_r == ST_DONE) && !out_busy_r;
    enter_round = (state_nxt == ST_ROUND) && (state_r != ST_ROUND);
    pad_fill = (state_r == ST_PAD2) ? '0 : fill_r;
    pad_mark = (state_r == ST_PAD);
    pad_len = (state_r == ST_PAD2) || (fill_r < LEN_START);
  end

  always_comb begin
    logic [5:0] b;
    logic [7:0] byte_val;
    for (int j = 0; j < BLOCK_WORDS; j++) begin
      for (int k = 0; k < 4; k++) begin
        b = {4'(j), 2'(k)};
        byte_val = wbuf_r[j][8 * (3 - k) +: 8];
        if (b < pad_fill) begin
          pad_words[j][8 * (3 - k) +: 8] = byte_val;
        end else if ((b == pad_fill) && pad_mark) begin
          pad_words[j][8 * (3 - k) +: 8] = PAD_MARK;
        end else begin
          pad_words[j][8 * (3 - k) +: 8] = '0;
        end
      end
    end
    if (pad_len) begin
      pad_words[BLOCK_WORDS - 2] = bits_r[63:32];
      pad_words[BLOCK_WORDS - 1] = bits_r[31:0];
    end
  end

  sha1md_round u_round (
    .cur (work_r),
    .w   (wbuf_r[0]),
    .rnd (rnd_r),
    .nxt (work_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r <= '0;
      bits_r <= '0;
      close_pend_r <= 1'b0;
      tail_r <= 1'b0;
      final_r <= 1'b0;
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        chain_r[i] <= INIT_WORDS[i];
      end
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        if (in_item.byte_present) begin
          fill_r <= fill_r + 6'd1;
          bits_r <= bits_r + 64'd8;
        end
        if (block_full) begin
          close_pend_r <= in_item.end_of_message;
        end
      end
      if (state_r == ST_PAD) begin
        tail_r <= (fill_r >= LEN_START);
        final_r <= (fill_r < LEN_START);
      end
      if (state_r == ST_PAD2) begin
        tail_r <= 1'b0;
        final_r <= 1'b1;
      end
      if (state_r == ST_FOLD) begin
        close_pend_r <= 1'b0;
        chain_r[0] <= chain_r[0] + work_r.a;
        chain_r[1] <= chain_r[1] + work_r.b;
        chain_r[2] <= chain_r[2] + work_r.c;
        chain_r[3] <= chain_r[3] + work_r.d;
        chain_r[4] <= chain_r[4] + work_r.e;
      end
      if (restart) begin
        final_r <= 1'b0;
        fill_r <= '0;
        bits_r <= '0;
        for (int i = 0; i < DIGEST_WORDS; i++) begin
          chain_r[i] <= INIT_WORDS[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_item.byte_present) begin
      wbuf_r[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] <= in_item.data_byte;
    end
    if (pad_en) begin
      for (int j = 0; j < BLOCK_WORDS; j++) begin
        wbuf_r[j] <= pad_words[j];
      end
    end
    if (state_r == ST_ROUND) begin
      for (int j = 0; j < BLOCK_WORDS - 1; j++) begin
        wbuf_r[j] <= wbuf_r[j + 1];
      end
      wbuf_r[BLOCK_WORDS - 1] <= rol1(wbuf_r[13] ^ wbuf_r[8] ^ wbuf_r[2] ^ wbuf_r[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (enter_round) begin
      work_r <= '{a: chain_r[0], b: chain_r[1], c: chain_r[2], d: chain_r[3],
                  e: chain_r[4]};
      rnd_r <= '0;
    end else if (state_r == ST_ROUND) begin
      work_r <= work_nxt;
      rnd_r <= rnd_r + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_busy_r <= 1'b0;
      out_idx_r <= '0;
    end else begin
      if (restart) begin
        out_busy_r <= 1'b1;
        out_idx_r <= '0;
      end else if (out_acc) begin
        out_idx_r <= out_idx_r + 3'd1;
        if (out_idx_r == LAST_INDEX) begin
          out_busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (restart) begin
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        dig_r[i] <= chain_r[i];
      end
    end else if (out_acc) begin
      for (int i = 0; i < DIGEST_WORDS - 1; i++) begin
        dig_r[i] <= dig_r[i + 1];
      end
    end
  end

  assign out_valid = out_busy_r;
  assign out_item.digest_word = dig_r[0];
  assign out_item.word_index = out_idx_r;
  assign out_item.last_word = (out_idx_r == LAST_INDEX);

endmodule
